FILE: rtl/core/imu_offset_calibrate_framer_top_macros.svh
// Assertion helpers for the checker file.
`ifndef IMU_OFFSET_CALIBRATE_FRAMER_TOP_MACROS_SVH
`define IMU_OFFSET_CALIBRATE_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define IMUF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("imuf check failed");

// Next-cycle implication, also checked across reset.
`define IMUF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("imuf check failed");

`endif

FILE: rtl/core/imuf_pkg.sv
package imuf_pkg;
   localparam int AXES     = 6;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 30;
   localparam int OFS_W    = 24;
   localparam int CNT_W    = 13;
   localparam int SIDX_W   = 3;
   localparam int BUF_N    = 25;

   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h55;

   localparam logic [1:0] MODE_CAL    = 2'd0;
   localparam logic [1:0] MODE_FINISH = 2'd1;
   localparam logic [1:0] MODE_STREAM = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic [7:0] REG_GRAVITY = 8'd0;
   localparam logic [7:0] REG_PTYPE   = 8'd1;

   typedef struct packed {
      logic              cal;
      logic              div_start;
      logic              ok;
      logic [SIDX_W-1:0] sid;
      logic [CNT_W-1:0]  count;
   } lane_ctl_type;
endpackage

FILE: rtl/core/imuf_if.sv
interface imuf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [1:0]  sensor_id;
   logic        read_ok;
   logic [31:0] timestamp_us;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   modport source (output valid, mode, sensor_id, read_ok, timestamp_us,
                   accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, input ready);
   modport sink (input valid, mode, sensor_id, read_ok, timestamp_us,
                 accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, output ready);
   modport monitor (input valid, ready, mode, sensor_id, read_ok, timestamp_us,
                    accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z);
endinterface

interface imuf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       frame_end;
   modport source (output valid, out_byte, last_of_run, frame_end, input ready);
   modport sink (input valid, out_byte, last_of_run, frame_end, output ready);
   modport monitor (input valid, ready, out_byte, last_of_run, frame_end);
endinterface

interface imuf_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

FILE: rtl/core/imuf_lane.sv
module imuf_lane #(
   parameter int SENSORS   = 3,
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  imuf_pkg::lane_ctl_type      ctl,
   input  logic signed [16:0]          sample,
   input  logic signed [15:0]          raw,
   output logic [15:0]                 corr,
   output logic                        div_done
);
   localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int SUM_W  = imuf_pkg::SUM_W;
   localparam int OFS_W  = imuf_pkg::OFS_W;
   localparam int CNT_W  = imuf_pkg::CNT_W;
   localparam int NUM_W  = SUM_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int VW     = (17 + FRAC_BITS > OFS_W + 1) ? 17 + FRAC_BITS : OFS_W + 1;
   localparam logic [VW-1:0] HALF = VW'((1 << FRAC_BITS) >> 1);
   localparam logic [NUM_W-1:0] Q_MAX = NUM_W'((1 << (OFS_W - 1)) - 1);
   localparam logic [NUM_W-1:0] Q_MIN_MAG = NUM_W'(1 << (OFS_W - 1));

   logic signed [SUM_W-1:0] sum_ff [SENSORS];
   logic signed [OFS_W-1:0] ofs_ff [SENSORS];

   logic [NUM_W-1:0]  num_ff, quo_ff;
   logic [CNT_W-1:0]  rem_ff, den_ff;
   logic [DCNT_W-1:0] step_ff;
   logic              busy_ff, neg_ff, done_ff;
   logic [IDX_W-1:0]  didx_ff;

   logic [IDX_W-1:0]        idx;
   logic signed [SUM_W-1:0] sum_sel;
   logic [SUM_W-1:0]        sum_mag;
   logic [CNT_W:0]          trial;
   logic                    fits;
   logic signed [OFS_W-1:0] q_final;

   assign idx     = IDX_W'(ctl.sid);
   assign sum_sel = sum_ff[idx];
   assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign fits    = trial >= {1'b0, den_ff};
   assign div_done = done_ff;

   always_comb begin
      if (neg_ff) begin
         q_final = (quo_ff > Q_MIN_MAG) ? OFS_W'(Q_MIN_MAG) : OFS_W'(-quo_ff);
      end else begin
         q_final = (quo_ff > Q_MAX) ? OFS_W'(Q_MAX) : OFS_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         for (int s = 0; s < SENSORS; s++) begin
            sum_ff[s] <= '0;
            ofs_ff[s] <= '0;
         end
      end else if (ctl.div_start) begin
         busy_ff <= 1'b1;
         num_ff  <= NUM_W'(sum_mag) << FRAC_BITS;
         neg_ff  <= sum_sel[SUM_W-1];
         den_ff  <= ctl.count;
         rem_ff  <= '0;
         quo_ff  <= '0;
         step_ff <= '0;
         didx_ff <= idx;
      end else if (busy_ff) begin
         if (step_ff == DCNT_W'(NUM_W)) begin
            // write the quotient back and clear the sum
            ofs_ff[didx_ff] <= q_final;
            sum_ff[didx_ff] <= '0;
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            rem_ff  <= fits ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
            quo_ff  <= {quo_ff[NUM_W-2:0], fits};
            num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
         end
      end else if (ctl.cal) begin
         sum_ff[idx] <= sum_sel + SUM_W'(sample);
      end
   end

   // stream correction: scale, subtract offset, round half away, saturate; zero when ctl.ok is low
   logic signed [VW-1:0] v;
   logic [VW-1:0]        mag, r;
   logic signed [OFS_W-1:0] ofs_sel;

   assign ofs_sel = ofs_ff[idx];
   assign v   = (VW'(raw) <<< FRAC_BITS) - VW'(ofs_sel);
   assign mag = v[VW-1] ? VW'(-v) : VW'(v);
   assign r   = (mag + HALF) >> FRAC_BITS;

   always_comb begin
      if (!ctl.ok) begin
         corr = '0;
      end else if (v[VW-1]) begin
         corr = (r > VW'(32768)) ? 16'h8000 : 16'(~r + 1'b1);
      end else begin
         corr = (r > VW'(32767)) ? 16'h7FFF : r[15:0];
      end
   end
endmodule

FILE: rtl/core/imuf_framer.sv
module imuf_framer #(
   parameter int SENSORS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                hdr,
   input  logic                tail,
   input  logic [7:0]          ptype,
   input  logic [31:0]         timestamp,
   input  logic [31:0]         frame_count,
   input  logic [15:0]         values [imuf_pkg::AXES],
   output logic                busy,
   imuf_rsp_if.source          rsp
);
   localparam logic [7:0] LEN = 8'(8 + 12 * SENSORS);
   localparam int N = imuf_pkg::BUF_N;

   logic [7:0] buf_ff [N];
   logic [7:0] buf_in [N];
   logic [4:0] left_ff, left_in;
   logic [7:0] ck_ff;
   logic       tail_ff;
   logic       valid_ff, last_ff, fend_ff;
   logic [7:0] byte_ff;
   logic       move;

   assign busy = left_ff != 5'd0;
   assign move = busy && (!valid_ff || rsp.ready);
   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.last_of_run = last_ff;
   assign rsp.frame_end   = fend_ff;

   always_comb begin
      logic [7:0] hb [12];
      logic [7:0] vb [12];
      hb[0] = imuf_pkg::SYNC_A;
      hb[1] = imuf_pkg::SYNC_B;
      hb[2] = ptype;
      hb[3] = LEN;
      for (int i = 0; i < 4; i++) begin
         hb[4 + i] = timestamp[8*i +: 8];
         hb[8 + i] = frame_count[8*i +: 8];
      end
      for (int a = 0; a < imuf_pkg::AXES; a++) begin
         vb[2*a]     = values[a][7:0];
         vb[2*a + 1] = values[a][15:8];
      end
      for (int i = 0; i < N; i++) buf_in[i] = '0;
      for (int i = 0; i < 12; i++) begin
         if (hdr) begin
            buf_in[i]      = hb[i];
            buf_in[12 + i] = vb[i];
         end else begin
            buf_in[i] = vb[i];
         end
      end
      left_in = (hdr ? 5'd24 : 5'd12) + {4'd0, tail};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         ck_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            buf_ff  <= buf_in;
            left_ff <= left_in;
            tail_ff <= tail;
            if (hdr) ck_ff <= '0;
         end else if (move) begin
            valid_ff <= 1'b1;
            last_ff  <= left_ff == 5'd1;
            if (left_ff == 5'd1 && tail_ff) begin
               byte_ff <= ck_ff;
               fend_ff <= 1'b1;
            end else begin
               byte_ff <= buf_ff[0];
               fend_ff <= 1'b0;
               ck_ff   <= ck_ff ^ buf_ff[0];
            end
            for (int i = 0; i < N - 1; i++) buf_ff[i] <= buf_ff[i + 1];
            left_ff <= left_ff - 1'b1;
         end
         if (!move && rsp.ready) valid_ff <= 1'b0;
      end
   end
endmodule

FILE: rtl/core/imu_offset_calibrate_framer_top.sv
// Channel  Dir  Handshake     Carries
// req      in   valid/ready   mode, sensor, read status, timestamp, six axes
// rsp      out  valid/ready   one frame byte with run and frame end marks
// csr      in   valid/ready   register index and write data, always ready
// A calibrate item passes through IDLE and EXEC; a stream item loads six
// lanes' corrected values into the byte shifter, then 12, 13, 24 or 25 bytes
// go out at one per cycle while rsp is ready. Finish runs each lane's
// bit-serial divider for each sensor with a nonzero count and skips the rest.
// Reset is synchronous and clears all sums, offsets and counts at once.
// A stalled rsp holds the byte shifter;
// req is taken again once the last byte sits in the output register.
module imu_offset_calibrate_framer_top #(
   parameter int SENSORS         = 3,
   parameter int MAX_CAL_SAMPLES = 4096,
   parameter int FRAC_BITS       = 8
) (
   input  logic        clock,
   input  logic        reset,
   imuf_req_if.sink    req,
   imuf_rsp_if.source  rsp,
   imuf_csr_if.sink    csr
);
   localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int AXES  = imuf_pkg::AXES;
   localparam int CNT_W = imuf_pkg::CNT_W;

   typedef enum logic [1:0] {IDLE, EXEC, FIN_NEXT, FIN_WAIT} state_type;

   state_type          state_ff;
   logic [1:0]         mode_ff, sid_ff;
   logic               ok_ff;
   logic [31:0]        ts_ff, fcnt_ff;
   logic signed [15:0] raw_ff [AXES];
   logic [14:0]        grav_ff;
   logic [7:0]         ptype_ff;
   logic [CNT_W-1:0]   count_ff [SENSORS];
   logic [IDX_W-1:0]   fs_ff;

   imuf_pkg::lane_ctl_type ctl;
   logic [15:0]        corr [AXES];
   logic [AXES-1:0]    done;
   logic               fr_busy, fr_load, sid_ok, cal_go;
   logic [IDX_W-1:0]   sidx;

   assign req.ready = (state_ff == IDLE) && !fr_busy;
   assign csr.ready = 1'b1;
   assign sid_ok    = 32'(sid_ff) < SENSORS;
   assign sidx      = IDX_W'(sid_ff);
   assign cal_go    = state_ff == EXEC && mode_ff == imuf_pkg::MODE_CAL && sid_ok && ok_ff
                      && count_ff[sidx] < CNT_W'(MAX_CAL_SAMPLES);
   assign fr_load   = state_ff == EXEC && mode_ff == imuf_pkg::MODE_STREAM && sid_ok;

   always_comb begin
      ctl.cal       = cal_go;
      ctl.div_start = 1'b0;
      ctl.ok        = ok_ff;
      ctl.sid       = imuf_pkg::SIDX_W'(sid_ff);
      ctl.count     = count_ff[fs_ff];
      if (state_ff == FIN_NEXT || state_ff == FIN_WAIT) begin
         ctl.sid = imuf_pkg::SIDX_W'(fs_ff);
         ctl.div_start = (state_ff == FIN_NEXT) && (count_ff[fs_ff] != '0);
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      logic signed [16:0] sample;
      if (a == 2) begin : g_z
         assign sample = 17'(raw_ff[a]) - $signed({2'b00, grav_ff});
      end else begin : g_xy
         assign sample = 17'(raw_ff[a]);
      end
      imuf_lane #(.SENSORS(SENSORS), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .reset(reset), .ctl(ctl), .sample(sample),
         .raw(raw_ff[a]), .corr(corr[a]), .div_done(done[a])
      );
   end

   imuf_framer #(.SENSORS(SENSORS)) u_framer (
      .clock(clock), .reset(reset), .load(fr_load),
      .hdr(sid_ff == 2'd0), .tail(32'(sid_ff) == SENSORS - 1),
      .ptype(ptype_ff), .timestamp(ts_ff), .frame_count(fcnt_ff),
      .values(corr), .busy(fr_busy), .rsp(rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         grav_ff  <= 15'd16384;
         ptype_ff <= 8'd1;
         fcnt_ff  <= '0;
         fs_ff    <= '0;
         for (int s = 0; s < SENSORS; s++) count_ff[s] <= '0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               imuf_pkg::REG_GRAVITY: grav_ff  <= csr.data[14:0];
               imuf_pkg::REG_PTYPE:   ptype_ff <= csr.data[7:0];
               default: ;
            endcase
         end
         case (state_ff)
            IDLE: begin
               if (req.valid && req.ready) begin
                  mode_ff   <= req.mode;
                  sid_ff    <= req.sensor_id;
                  ok_ff     <= req.read_ok;
                  ts_ff     <= req.timestamp_us;
                  raw_ff[0] <= req.accel_x;
                  raw_ff[1] <= req.accel_y;
                  raw_ff[2] <= req.accel_z;
                  raw_ff[3] <= req.gyro_x;
                  raw_ff[4] <= req.gyro_y;
                  raw_ff[5] <= req.gyro_z;
                  state_ff  <= EXEC;
               end
            end
            EXEC: begin
               state_ff <= IDLE;
               if (cal_go) count_ff[sidx] <= count_ff[sidx] + 1'b1;
               if (fr_load && sid_ff == 2'd0) fcnt_ff <= fcnt_ff + 1'b1;
               if (mode_ff == imuf_pkg::MODE_FINISH) begin
                  fs_ff    <= '0;
                  state_ff <= FIN_NEXT;
               end
            end
            FIN_NEXT: begin
               if (count_ff[fs_ff] != '0) begin
                  state_ff <= FIN_WAIT;
               end else if (32'(fs_ff) == SENSORS - 1) begin
                  state_ff <= IDLE;
               end else begin
                  fs_ff <= fs_ff + 1'b1;
               end
            end
            FIN_WAIT: begin
               if (done[0]) begin
                  count_ff[fs_ff] <= '0;
                  if (32'(fs_ff) == SENSORS - 1) begin
                     state_ff <= IDLE;
                  end else begin
                     fs_ff    <= fs_ff + 1'b1;
                     state_ff <= FIN_NEXT;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/core/imuf_checker.sv
`include "imu_offset_calibrate_framer_top_macros.svh"

module imuf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_last,
   input logic       rsp_fend
);
   `IMUF_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid)
   `IMUF_ASSERT_IMPL(a_fend_last, rsp_valid && rsp_fend, rsp_last)
   // more bytes pending: no new item taken
   `IMUF_ASSERT_IMPL(a_busy_blocks, rsp_valid && !rsp_last, !req_ready)
   `IMUF_ASSERT_NEXT(a_hold, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte))
endmodule

bind imu_offset_calibrate_framer_top imuf_checker u_imuf_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_byte(rsp.out_byte),
   .rsp_last(rsp.last_of_run), .rsp_fend(rsp.frame_end)
);
